// ===== design/rgbe_dec_pkg.sv =====
package rgbe_dec_pkg;

  // Decoder phases of the byte stream.
  typedef enum logic [2:0] {
    PH_MARK,
    PH_COUNT,
    PH_RUNVAL,
    PH_LIT,
    PH_FLAT,
    PH_DONE,
    PH_HALT
  } phase_t;

  // Status codes carried with each result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WIDTH = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  // Configuration register indexes.
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Request kinds on the input channel.
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Byte values of the scanline marker and run count split.
  localparam logic [7:0] MARK_BYTE = 8'd2;
  localparam logic [7:0] RUN_SPLIT = 8'd128;
  localparam logic [14:0] MIN_RLE_WIDTH = 15'd8;

  // One entry of the queue between front and back.
  typedef struct packed {
    logic        is_err;
    logic [1:0]  status;
    logic [23:0] rgb;
    logic [7:0]  e;
    logic        done;
    logic        last;
  } pkt_t;

  // Control from the queue to the back end.
  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } head_t;

  // Mantissa byte m scaled by 2^(e-136) as IEEE single bits; exact, subnormals included.
  function automatic logic [31:0] chan_bits(input logic [7:0] m, input logic [7:0] e);
    logic [2:0]  h;
    logic [8:0]  s;
    logic [31:0] wide;
    logic [31:0] r;
    h = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (m[i]) h = 3'(i);
    end
    s = {6'd0, h} + {1'b0, e};
    wide = {24'd0, m} << (5'd23 - {2'd0, h});
    if (e == 8'd0 || m == 8'd0) begin
      r = 32'd0;
    end else if (s >= 9'd10) begin
      r = {1'b0, 8'(s - 9'd9), wide[22:0]};
    end else begin
      r = {24'd0, m} << (e[4:0] + 5'd13);
    end
    return r;
  endfunction

endpackage

// ===== design/rgbe_dec_ram.sv =====
module rgbe_dec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rgbe_dec_queue.sv =====
module rgbe_dec_queue #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  rgbe_dec_pkg::pkt_t           push_pkt,
  input  logic                         pop,
  output rgbe_dec_pkg::head_t          head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rgbe_dec_pkg::pkt_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  assign head.valid = (count != '0);
  assign head.pkt   = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_pkt;
  end

  // Pointers and fill level; pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/rgbe_dec_front.sv =====
module rgbe_dec_front #(
  parameter int MAX_WIDTH = 8192,
  parameter int DEPTH     = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  input  logic                             s_tuser,
  input  logic [14:0]                      line_width,
  input  logic [15:0]                      line_count,
  input  logic [$clog2(DEPTH+1)-1:0]       fifo_count,
  output logic                             push,
  output rgbe_dec_pkg::pkt_t               push_pkt,
  output logic [2:0]                       ram_we,
  output logic [$clog2(MAX_WIDTH)-1:0]     ram_addr,
  output logic [7:0]                       ram_wdata,
  input  logic [23:0]                      ram_rdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  rgbe_dec_pkg::phase_t phase, phase_next;
  logic [23:0] group_bytes, group_bytes_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [1:0]  plane_index, plane_index_next;
  logic [14:0] plane_pos, plane_pos_next;
  logic [7:0]  chunk_left, chunk_left_next;
  logic [15:0] lines_left, lines_left_next;
  logic [30:0] pixels_left, pixels_left_next;
  logic        expanding, expanding_next;
  logic [7:0]  run_val, run_val_next;

  logic               pend_valid, pend_valid_next;
  rgbe_dec_pkg::pkt_t pend_pkt, pend_pkt_next;
  logic               pend_ram, pend_ram_next;
  logic               pend_oob, pend_oob_next;

  logic        space_ok;
  logic        accept;
  logic        do_put;
  logic [7:0]  put_val;
  logic        put_last;
  logic [15:0] ll;
  logic [15:0] pos_inc;
  logic [30:0] total;
  logic [30:0] pl;
  logic [7:0]  cnt;
  logic [14:0] room;

  // Room for one more entry next cycle, counting the one in flight.
  assign space_ok = ({1'b0, fifo_count} + (CW + 1)'(pend_valid)) < (CW + 1)'(DEPTH);
  assign s_tready = !expanding && space_ok;
  assign accept   = s_tvalid && s_tready;

  // A pending pixel picks up its colors from the store in the cycle after the read.
  always_comb begin
    push_pkt = pend_pkt;
    if (pend_ram) push_pkt.rgb = pend_oob ? 24'd0 : ram_rdata;
  end
  assign push = pend_valid;

  // Byte decoding and store access.
  always_comb begin
    phase_next       = phase;
    group_bytes_next = group_bytes;
    group_fill_next  = group_fill;
    plane_index_next = plane_index;
    plane_pos_next   = plane_pos;
    chunk_left_next  = chunk_left;
    lines_left_next  = lines_left;
    pixels_left_next = pixels_left;
    expanding_next   = expanding;
    run_val_next     = run_val;
    pend_valid_next  = 1'b0;
    pend_pkt_next    = '0;
    pend_ram_next    = 1'b0;
    pend_oob_next    = 1'b0;
    do_put   = 1'b0;
    put_val  = s_tdata;
    put_last = 1'b0;
    ram_we   = 3'b000;
    ram_addr = plane_pos[AW-1:0];
    ram_wdata = put_val;
    ll    = lines_left;
    total = '0;
    pl    = '0;
    cnt   = (s_tdata > rgbe_dec_pkg::RUN_SPLIT) ? s_tdata - rgbe_dec_pkg::RUN_SPLIT : s_tdata;
    room  = (line_width > plane_pos) ? line_width - plane_pos : 15'd0;
    pos_inc = {1'b0, plane_pos} + 16'd1;

    if (expanding) begin
      // One value of a run per cycle while the queue has room.
      if (space_ok) begin
        do_put          = 1'b1;
        put_val         = run_val;
        chunk_left_next = chunk_left - 8'd1;
        put_last        = (chunk_left == 8'd1);
      end
    end else if (accept) begin
      if (s_tuser == rgbe_dec_pkg::REQ_START) begin
        phase_next       = rgbe_dec_pkg::PH_MARK;
        group_bytes_next = '0;
        group_fill_next  = '0;
        plane_index_next = '0;
        plane_pos_next   = '0;
        chunk_left_next  = '0;
        lines_left_next  = '0;
        pixels_left_next = '0;
      end else begin
        unique case (phase)
          rgbe_dec_pkg::PH_MARK, rgbe_dec_pkg::PH_FLAT: begin
            if (phase == rgbe_dec_pkg::PH_MARK && group_fill == 2'd0 && lines_left == 16'd0) begin
              if (line_count == 16'd0 || line_width == 15'd0) begin
                phase_next = rgbe_dec_pkg::PH_DONE;
              end else begin
                ll = line_count;
                lines_left_next = line_count;
              end
            end
            if (phase_next != rgbe_dec_pkg::PH_DONE) begin
              if (group_fill != 2'd3) begin
                group_bytes_next = group_bytes | ({16'd0, s_tdata} << (5'd8 * (5'd2 - 5'(group_fill))));
                group_fill_next  = group_fill + 2'd1;
              end else begin
                group_bytes_next = '0;
                group_fill_next  = '0;
                if (phase == rgbe_dec_pkg::PH_FLAT) begin
                  pixels_left_next = pixels_left - 31'd1;
                  if (pixels_left_next == 31'd0) phase_next = rgbe_dec_pkg::PH_DONE;
                  pend_valid_next = 1'b1;
                  pend_pkt_next.rgb  = group_bytes;
                  pend_pkt_next.e    = s_tdata;
                  pend_pkt_next.done = (pixels_left_next == 31'd0);
                  pend_pkt_next.last = 1'b1;
                end else if (line_width < rgbe_dec_pkg::MIN_RLE_WIDTH
                             || group_bytes[23:16] != rgbe_dec_pkg::MARK_BYTE
                             || group_bytes[15:8] != rgbe_dec_pkg::MARK_BYTE
                             || group_bytes[7]) begin
                  // Not a marker, or a line narrower than the run-length minimum: flat pixels to the end of the image.
                  total = 31'(ll * line_width);
                  pl    = (total == 31'd0) ? 31'd0 : total - 31'd1;
                  pixels_left_next = pl;
                  phase_next = (pl == 31'd0) ? rgbe_dec_pkg::PH_DONE : rgbe_dec_pkg::PH_FLAT;
                  pend_valid_next = 1'b1;
                  pend_pkt_next.rgb  = group_bytes;
                  pend_pkt_next.e    = s_tdata;
                  pend_pkt_next.done = (pl == 31'd0);
                  pend_pkt_next.last = 1'b1;
                end else if ({group_bytes[6:0], s_tdata} != line_width) begin
                  pend_valid_next = 1'b1;
                  pend_pkt_next.is_err = 1'b1;
                  pend_pkt_next.status = rgbe_dec_pkg::ST_WIDTH;
                  pend_pkt_next.last   = 1'b1;
                  phase_next = rgbe_dec_pkg::PH_HALT;
                end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
                  pend_valid_next = 1'b1;
                  pend_pkt_next.is_err = 1'b1;
                  pend_pkt_next.status = rgbe_dec_pkg::ST_LIMIT;
                  pend_pkt_next.last   = 1'b1;
                  phase_next = rgbe_dec_pkg::PH_HALT;
                end else begin
                  phase_next = rgbe_dec_pkg::PH_COUNT;
                  plane_index_next = '0;
                  plane_pos_next   = '0;
                end
              end
            end
          end
          rgbe_dec_pkg::PH_COUNT: begin
            if (cnt == 8'd0 || 15'(cnt) > room) begin
              pend_valid_next = 1'b1;
              pend_pkt_next.is_err = 1'b1;
              pend_pkt_next.status = rgbe_dec_pkg::ST_COUNT;
              pend_pkt_next.last   = 1'b1;
              phase_next = rgbe_dec_pkg::PH_HALT;
            end else begin
              chunk_left_next = cnt;
              phase_next = (s_tdata > rgbe_dec_pkg::RUN_SPLIT) ? rgbe_dec_pkg::PH_RUNVAL
                                                              : rgbe_dec_pkg::PH_LIT;
            end
          end
          rgbe_dec_pkg::PH_RUNVAL: begin
            run_val_next = s_tdata;
            if (chunk_left == 8'd0) phase_next = rgbe_dec_pkg::PH_COUNT;
            else expanding_next = 1'b1;
          end
          rgbe_dec_pkg::PH_LIT: begin
            if (chunk_left != 8'd0) chunk_left_next = chunk_left - 8'd1;
            do_put   = 1'b1;
            put_last = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    // Place one value: a store write for color planes, a pixel for the exponent plane.
    if (do_put) begin
      ram_wdata = put_val;
      if (plane_index != 2'd3) begin
        if (32'(plane_pos) < 32'(MAX_WIDTH)) ram_we = 3'b100 >> plane_index;
      end else begin
        pend_valid_next    = 1'b1;
        pend_ram_next      = 1'b1;
        pend_oob_next      = (32'(plane_pos) >= 32'(MAX_WIDTH));
        pend_pkt_next.e    = put_val;
        pend_pkt_next.done = (pos_inc >= {1'b0, line_width}) && (lines_left <= 16'd1);
        pend_pkt_next.last = put_last;
      end
      if (pos_inc >= {1'b0, line_width}) begin
        plane_pos_next = '0;
        if (plane_index == 2'd3) begin
          plane_index_next = '0;
          lines_left_next  = lines_left - 16'd1;
          phase_next = (lines_left_next == 16'd0) ? rgbe_dec_pkg::PH_DONE : rgbe_dec_pkg::PH_MARK;
        end else begin
          plane_index_next = plane_index + 2'd1;
        end
      end else begin
        plane_pos_next = pos_inc[14:0];
      end
      if (expanding && put_last) begin
        expanding_next = 1'b0;
        if (phase_next == rgbe_dec_pkg::PH_RUNVAL) phase_next = rgbe_dec_pkg::PH_COUNT;
      end
      if (!expanding && phase_next == rgbe_dec_pkg::PH_LIT && chunk_left_next == 8'd0) begin
        phase_next = rgbe_dec_pkg::PH_COUNT;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rgbe_dec_pkg::PH_MARK;
      group_bytes <= '0;
      group_fill  <= '0;
      plane_index <= '0;
      plane_pos   <= '0;
      chunk_left  <= '0;
      lines_left  <= '0;
      pixels_left <= '0;
      expanding   <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      phase       <= phase_next;
      group_bytes <= group_bytes_next;
      group_fill  <= group_fill_next;
      plane_index <= plane_index_next;
      plane_pos   <= plane_pos_next;
      chunk_left  <= chunk_left_next;
      lines_left  <= lines_left_next;
      pixels_left <= pixels_left_next;
      expanding   <= expanding_next;
      pend_valid  <= pend_valid_next;
    end
  end

  // Payload of the in-flight entry and the run value.
  always_ff @(posedge clk) begin
    run_val  <= run_val_next;
    pend_pkt <= pend_pkt_next;
    pend_ram <= pend_ram_next;
    pend_oob <= pend_oob_next;
  end

endmodule

// ===== design/rgbe_dec_back.sv =====
module rgbe_dec_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rgbe_dec_pkg::head_t  head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [199:0]         m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);

  logic        hold_valid;
  logic [31:0] hold_r, hold_g, hold_b;
  logic        hold_done;
  logic [31:0] cur_r, cur_g, cur_b;
  logic        out_free;
  logic        load_err, load_one, load_pair, take_hold;

  // Float conversion of the entry at the queue head.
  assign cur_r = rgbe_dec_pkg::chan_bits(head.pkt.rgb[23:16], head.pkt.e);
  assign cur_g = rgbe_dec_pkg::chan_bits(head.pkt.rgb[15:8], head.pkt.e);
  assign cur_b = rgbe_dec_pkg::chan_bits(head.pkt.rgb[7:0], head.pkt.e);

  assign out_free = !m_tvalid || m_tready;

  // Pair pixels into results; the last entry of a request closes its result.
  always_comb begin
    load_err  = 1'b0;
    load_one  = 1'b0;
    load_pair = 1'b0;
    take_hold = 1'b0;
    if (head.valid) begin
      if (head.pkt.is_err) load_err = out_free;
      else if (!hold_valid) begin
        if (head.pkt.last) load_one = out_free;
        else take_hold = 1'b1;
      end else begin
        load_pair = out_free;
      end
    end
    pop = load_err || load_one || load_pair || take_hold;
  end

  // Held first pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take_hold) begin
      hold_valid <= 1'b1;
    end else if (load_pair) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_hold) begin
      hold_r    <= cur_r;
      hold_g    <= cur_g;
      hold_b    <= cur_b;
      hold_done <= head.pkt.done;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_err || load_one || load_pair) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      m_tdata <= '0;
      m_tuser <= head.pkt.status;
      m_tlast <= 1'b1;
    end else if (load_one) begin
      m_tdata <= {5'd0, head.pkt.done, 1'b0, 96'd0, 1'b1, cur_b, cur_g, cur_r};
      m_tuser <= rgbe_dec_pkg::ST_OK;
      m_tlast <= 1'b1;
    end else if (load_pair) begin
      m_tdata <= {5'd0, hold_done | head.pkt.done, 1'b1, cur_b, cur_g, cur_r,
                  1'b1, hold_b, hold_g, hold_r};
      m_tuser <= rgbe_dec_pkg::ST_OK;
      m_tlast <= head.pkt.last;
    end
  end

endmodule

// ===== design/rgbe_rle_scanline_decoder_core.sv =====
// RGBE run-length scanline decoder.
// Input stream: one request per byte of the pixel data that follows the image
// header. tuser selects a data byte (0) or the start of a new image (1); a start
// request clears the decode state and produces no result.
// Output stream: each result carries up to two pixels as IEEE single floats,
// their valid bits and an image-done flag in tdata, the status in tuser, and
// tlast on the final result caused by one input request.
// Configuration: write line_width (index 0) and line_count (index 1) through
// cfg_we/cfg_index/cfg_data while the decoder is idle.
// Throughput: one byte per cycle while the queue has room, for markers, counts,
// literals and flat pixels. A run value byte holds the input while its value
// repeats, since the front end places one value into the line store or emits
// one pixel a cycle while the queue has room. The byte of a result's last pixel
// passes the store read and in-flight entry register, the queue write, then the
// output register. The first pixel of a pair waits for its partner.
// When the receiver stalls, the queue fills and then the input stops accepting.
// After reset the decoder waits for the first marker of an image; the line
// store holds no valid data and needs no clearing.
module rgbe_rle_scanline_decoder_core #(
  parameter int MAX_WIDTH = 8192
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  // first_red, first_green, first_blue, first_valid, second_red, second_green,
  // second_blue, second_valid, image_done, zero fill
  output logic [199:0] m_tdata,
  output logic [1:0]   m_tuser,   // status
  output logic         m_tlast,   // final_of_input
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [14:0] line_width;
  logic [15:0] line_count;

  logic                push;
  rgbe_dec_pkg::pkt_t  push_pkt;
  logic                pop;
  rgbe_dec_pkg::head_t head;
  logic [CW-1:0]       fifo_count;
  logic [2:0]          ram_we;
  logic [AW-1:0]       ram_addr;
  logic [7:0]          ram_wdata;
  logic [23:0]         ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 15'd8;
      line_count <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == rgbe_dec_pkg::REG_WIDTH) line_width <= cfg_data[14:0];
      else line_count <= cfg_data;
    end
  end

  rgbe_dec_front #(.MAX_WIDTH(MAX_WIDTH), .DEPTH(DEPTH)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .line_width(line_width), .line_count(line_count),
    .fifo_count(fifo_count), .push(push), .push_pkt(push_pkt),
    .ram_we(ram_we), .ram_addr(ram_addr), .ram_wdata(ram_wdata), .ram_rdata(ram_rdata)
  );

  // Line store: one byte-wide memory per color plane.
  rgbe_dec_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_r (
    .clk(clk), .we(ram_we[2]), .waddr(ram_addr), .wdata(ram_wdata),
    .raddr(ram_addr), .rdata(ram_rdata[23:16])
  );
  rgbe_dec_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_g (
    .clk(clk), .we(ram_we[1]), .waddr(ram_addr), .wdata(ram_wdata),
    .raddr(ram_addr), .rdata(ram_rdata[15:8])
  );
  rgbe_dec_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram_b (
    .clk(clk), .we(ram_we[0]), .waddr(ram_addr), .wdata(ram_wdata),
    .raddr(ram_addr), .rdata(ram_rdata[7:0])
  );

  rgbe_dec_queue #(.DEPTH(DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_pkt(push_pkt),
    .pop(pop), .head(head), .count(fifo_count)
  );

  rgbe_dec_back u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule
